// ----- sv/nmea_sentence_checksum_framer_macros.svh -----
// Assertion helpers for the sentence framer. Every check is clocked on clk
// and is disabled while arst_n is low.
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_MACROS_SVH

// Same-cycle implication
`define NSCF_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nscf check failed");

// Next-cycle implication
`define NSCF_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nscf check failed");

`endif

// ----- sv/nscf_pkg.sv -----
package nscf_pkg;

	// Framing characters
	localparam logic [7:0] CH_DOLLAR = 8'd36;
	localparam logic [7:0] CH_STAR   = 8'd42;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_F = 8'd70;
	// 'A' (65) decodes to 10, so letters are offset by 7 past the digits
	localparam logic [3:0] HEX_ALPHA_ADJ = 4'd7;

	localparam int unsigned TITLE_LEN = 5;
	localparam int unsigned TITLE_CNT_W = $clog2(TITLE_LEN + 1);

	// Known titles, first character in the low byte
	localparam logic [39:0] TITLE_PUWV0 = 40'h30_56_57_55_50;
	localparam logic [39:0] TITLE_PUWVE = 40'h45_56_57_55_50;
	localparam logic [39:0] TITLE_PUWV7 = 40'h37_56_57_55_50;
	localparam logic [39:0] TITLE_PUWV4 = 40'h34_56_57_55_50;
	localparam logic [39:0] TITLE_PUWV3 = 40'h33_56_57_55_50;

	typedef enum logic [2:0] {
		CLS_PUWV0 = 3'd0,
		CLS_PUWVE = 3'd1,
		CLS_PUWV7 = 3'd2,
		CLS_PUWV4 = 3'd3,
		CLS_PUWV3 = 3'd4,
		CLS_OTHER = 3'd5
	} nscf_class_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_HEX1 = 2'd2,
		PH_HEX2 = 2'd3
	} nscf_phase_t;

	// One finished sentence, as produced by the parser for one byte
	typedef struct packed {
		logic        hit;
		nscf_class_t cls;
		logic        ok;
		logic [7:0]  calc;
		logic [7:0]  rcvd;
	} nscf_result_t;

endpackage

// ----- sv/nmea_sentence_checksum_framer.sv -----
// NMEA 0183 sentence checksum framer. Feed received characters one per beat
// on rx_byte; a '$' (re)starts a sentence, the bytes up to '*' are XORed and
// the first five kept as the title, and the two uppercase hex characters after
// '*' are compared with the XOR. On the second hex character one result beat
// is emitted with the title class, both checksums and a match flag; all other
// bytes give no result. Throughput is one byte per clock when the output is not
// stalled: each byte is held in an input register while the parser updates its
// state, and a result is then registered in the output register. Input is only
// held back while a result waits unread.
`include "nmea_sentence_checksum_framer_macros.svh"

module nmea_sentence_checksum_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] sentence_class,
	output logic       checksum_ok,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);
	import nscf_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         step;
	nscf_result_t res;
	logic         out_valid_q;
	logic [2:0]   class_q;
	logic         ok_q;
	logic [7:0]   calc_q;
	logic [7:0]   rcvd_q;

	// Parse the staged byte once the output register can take a result
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	nscf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.hit) begin
			class_q <= res.cls;
			ok_q    <= res.ok;
			calc_q  <= res.calc;
			rcvd_q  <= res.rcvd;
		end
	end

	assign out_valid      = out_valid_q;
	assign sentence_class = class_q;
	assign checksum_ok    = ok_q;
	assign computed_sum   = calc_q;
	assign received_sum   = rcvd_q;

	// Checks
	`NSCF_CHECK_NEXT(a_hit_loads_out, res.hit, out_valid_q)
	`NSCF_CHECK_NOW(a_hit_needs_room, res.hit, step && (!out_valid_q || out_ready))
	`NSCF_CHECK_NOW(a_ok_means_equal, out_valid_q && ok_q, calc_q == rcvd_q)
	`NSCF_CHECK_NEXT(a_stall_holds_byte, valid_s1 && !step, valid_s1 && $stable(byte_s1))

endmodule

// ----- sv/nscf_parser.sv -----
module nscf_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output nscf_pkg::nscf_result_t res
);
	import nscf_pkg::*;

	nscf_phase_t                    phase_q, phase_d;
	logic [7:0]                     xor_q;
	logic [TITLE_LEN-1:0][7:0]      title_q;
	logic [TITLE_CNT_W-1:0]         title_cnt_q;
	logic [3:0]                     hi_nib_q;
	logic                           hex_bad_q;

	logic                           is_dollar;
	logic                           is_star;
	logic                           byte_bad;
	logic [3:0]                     byte_nib;
	logic [7:0]                     rx_sum;

	assign is_dollar = (rx_byte == CH_DOLLAR);
	assign is_star   = (rx_byte == CH_STAR);

	// Hex decode: bytes above '9' drop by 7 in the low nibble, anything else keeps it
	assign byte_nib = (rx_byte > CH_NINE) ? (rx_byte[3:0] - HEX_ALPHA_ADJ) : rx_byte[3:0];
	assign byte_bad = !(((rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE)) ||
		((rx_byte >= CH_UPPER_A) && (rx_byte <= CH_UPPER_F)));
	assign rx_sum   = {hi_nib_q, byte_nib};

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (is_dollar) begin
				phase_d = PH_BODY;
			end else begin
				case (phase_q)
					PH_BODY: if (is_star) phase_d = PH_HEX1;
					PH_HEX1: phase_d = PH_HEX2;
					PH_HEX2: phase_d = PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Result for the current byte
	always_comb begin
		res.hit  = step && !is_dollar && (phase_q == PH_HEX2);
		res.cls  = CLS_OTHER;
		if (title_cnt_q == TITLE_CNT_W'(TITLE_LEN)) begin
			case (title_q)
				TITLE_PUWV0: res.cls = CLS_PUWV0;
				TITLE_PUWVE: res.cls = CLS_PUWVE;
				TITLE_PUWV7: res.cls = CLS_PUWV7;
				TITLE_PUWV4: res.cls = CLS_PUWV4;
				TITLE_PUWV3: res.cls = CLS_PUWV3;
				default:     res.cls = CLS_OTHER;
			endcase
		end
		res.ok   = !hex_bad_q && !byte_bad && (rx_sum == xor_q);
		res.calc = xor_q;
		res.rcvd = rx_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Sentence accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q       <= '0;
			title_q     <= '0;
			title_cnt_q <= '0;
			hi_nib_q    <= '0;
			hex_bad_q   <= 1'b0;
		end else if (step) begin
			if (is_dollar) begin
				xor_q       <= '0;
				title_q     <= '0;
				title_cnt_q <= '0;
				hi_nib_q    <= '0;
				hex_bad_q   <= 1'b0;
			end else begin
				case (phase_q)
					PH_BODY: begin
						if (is_star) begin
							hex_bad_q <= 1'b0;
						end else begin
							xor_q <= xor_q ^ rx_byte;
							if (title_cnt_q < TITLE_CNT_W'(TITLE_LEN)) begin
								for (int i = 0; i < TITLE_LEN; i++) begin
									if (title_cnt_q == TITLE_CNT_W'(i)) title_q[i] <= rx_byte;
								end
								title_cnt_q <= title_cnt_q + 1'b1;
							end
						end
					end
					PH_HEX1: begin
						hi_nib_q <= byte_nib;
						if (byte_bad) hex_bad_q <= 1'b1;
					end
					PH_HEX2: begin
						if (byte_bad) hex_bad_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule
